>>> rtl/slrc_pkg.sv
// Shared types and constants for the split-line rectangle clipper.
`timescale 1ns / 1ps
`default_nettype none

package slrc_pkg;

    localparam int COORD_BITS = 24;
    localparam int SLOPE_FRAC = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int QUO_W      = DIFF_W + SLOPE_FRAC;
    localparam int DIV_ST     = (QUO_W + 1) / 2;
    localparam int DQ_W       = 2 * DIV_ST;
    localparam int QS_W       = DQ_W + 1;
    localparam int DIV_LAT    = DIV_ST + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [QS_W-1:0]       t_quot;

    typedef struct packed {
        t_coord line_x1;
        t_coord line_y1;
        t_coord line_x2;
        t_coord line_y2;
        t_coord rect_left;
        t_coord rect_right;
        t_coord rect_top;
        t_coord rect_bottom;
    } t_line_in;

    typedef struct packed {
        t_coord out_x1;
        t_coord out_y1;
        t_coord out_x2;
        t_coord out_y2;
        logic   is_empty;
    } t_line_out;

endpackage

`default_nettype wire

>>> rtl/slrc_div.sv
// Pipelined signed slope divider: trunc(num * 2^16 / den), two quotient bits a stage.
`timescale 1ns / 1ps
`default_nettype none

module slrc_div (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire slrc_pkg::t_diff i_num,
    input  wire slrc_pkg::t_diff i_den,
    output slrc_pkg::t_quot      o_quot
);
    import slrc_pkg::*;

    localparam int R_W = DIFF_W + 1;

    logic [DQ_W-1:0]   r_acc [0:DIV_ST];
    logic [R_W-1:0]    r_rem [0:DIV_ST];
    logic [DIFF_W-1:0] r_den [0:DIV_ST];
    logic              r_neg [0:DIV_ST];
    t_quot             r_quot;

    logic [DQ_W-1:0]   n_acc [1:DIV_ST];
    logic [R_W-1:0]    n_rem [1:DIV_ST];
    logic [DIFF_W-1:0] num_mag;
    logic [DIFF_W-1:0] den_mag;
    t_quot             n_quot;

    always_comb begin
        num_mag = i_num[DIFF_W-1] ? DIFF_W'(-i_num) : DIFF_W'(i_num);
        den_mag = i_den[DIFF_W-1] ? DIFF_W'(-i_den) : DIFF_W'(i_den);
    end

    // restoring division, two bits per stage
    always_comb begin
        logic [DQ_W-1:0] acc;
        logic [R_W-1:0]  rem;
        logic [R_W-1:0]  sh;
        for (int k = 0; k < DIV_ST; k++) begin
            acc = r_acc[k];
            rem = r_rem[k];
            for (int j = 0; j < 2; j++) begin
                sh  = {rem[R_W-2:0], acc[DQ_W-1]};
                acc = {acc[DQ_W-2:0], 1'b0};
                if (sh >= {1'b0, r_den[k]}) begin
                    sh     = sh - {1'b0, r_den[k]};
                    acc[0] = 1'b1;
                end
                rem = sh;
            end
            n_acc[k+1] = acc;
            n_rem[k+1] = rem;
        end
    end

    always_comb begin
        n_quot = r_neg[DIV_ST] ? t_quot'(-{1'b0, r_acc[DIV_ST]})
                               : t_quot'({1'b0, r_acc[DIV_ST]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0] <= DQ_W'({num_mag, {SLOPE_FRAC{1'b0}}});
            r_rem[0] <= '0;
            r_den[0] <= den_mag;
            r_neg[0] <= i_num[DIFF_W-1] ^ i_den[DIFF_W-1];
            for (int k = 0; k < DIV_ST; k++) begin
                r_acc[k+1] <= n_acc[k+1];
                r_rem[k+1] <= n_rem[k+1];
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
            end
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> rtl/split_line_rect_clipper.sv
// Top level of the split-line rectangle clipper: extend, clip and output skid.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------
//  in      | i_in_valid  | o_in_stall  | i_in_data  (t_line_in)
//  out     | o_out_valid | i_out_stall | o_out_data (t_line_out)
//
// One transaction in per cycle while o_in_stall is low.
// Most of the latency is in the two pipelined slope dividers.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// The whole pipeline moves while the skid register is empty; a stalled output fills
// the skid and the input stalls until it drains.
`timescale 1ns / 1ps
`default_nettype none

module split_line_rect_clipper (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire slrc_pkg::t_line_in i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output slrc_pkg::t_line_out     o_out_data
);
    import slrc_pkg::*;

    localparam int S1_W = SLOPE_FRAC + 2;
    localparam int P1_W = DIFF_W + S1_W;
    localparam int Q1_W = P1_W - SLOPE_FRAC;
    localparam int A1_W = Q1_W + 1;
    localparam int SL_W = QS_W / 2;
    localparam int SH_W = QS_W - SL_W;
    localparam int PL_W = DIFF_W + SL_W + 1;
    localparam int PH_W = DIFF_W + SH_W;
    localparam int P2_W = DIFF_W + QS_W;
    localparam int Q2_W = P2_W - SLOPE_FRAC;
    localparam int A2_W = Q2_W + 1;

    localparam logic signed [A1_W-1:0] SAT_MAX_E =
        {{(A1_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [A1_W-1:0] SAT_MIN_E =
        {{(A1_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [A2_W-1:0] SAT_MAX_K =
        {{(A2_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [A2_W-1:0] SAT_MIN_K =
        {{(A2_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic   steep;
        logic   deg;
        t_coord a0;
        t_diff  d1;
        t_diff  d2;
        t_coord t1;
        t_coord t2;
        t_coord ou1;
        t_coord ov1;
        t_coord ou2;
        t_coord ov2;
        t_coord lo;
        t_coord hi;
    } t_ext;

    typedef struct packed {
        logic   steep;
        t_coord u1;
        t_coord v1;
        t_coord u2;
        t_coord v2;
        t_coord lo;
        t_coord hi;
    } t_seg;

    typedef struct packed {
        logic   steep;
        logic   eq;
        logic   outside;
        logic   nlo;
        logic   nhi;
        t_coord au;
        t_coord av;
        t_coord bu;
        t_coord bv;
        t_coord lo;
        t_coord hi;
        t_coord v1;
        t_diff  dlo;
        t_diff  dhi;
    } t_clip;

    function automatic t_coord sat_e(input logic signed [A1_W-1:0] v);
        if (v > SAT_MAX_E) return SAT_MAX_E[COORD_BITS-1:0];
        if (v < SAT_MIN_E) return SAT_MIN_E[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    function automatic t_coord sat_k(input logic signed [A2_W-1:0] v);
        if (v > SAT_MAX_K) return SAT_MAX_K[COORD_BITS-1:0];
        if (v < SAT_MIN_K) return SAT_MIN_K[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    // control
    logic en;
    logic inc;
    logic take;

    // stage registers
    logic     r_s1_v;
    t_line_in r_s1;
    logic     r_s2_v;
    t_line_in r_s2;
    t_diff    r_s2_dx;
    t_diff    r_s2_dy;

    logic     r_d1_v [0:DIV_LAT-1];
    t_ext     r_d1   [0:DIV_LAT-1];
    t_quot    div1_q;

    logic                   r_m1_v;
    t_ext                   r_m1;
    logic signed [P1_W-1:0] r_m1_p1;
    logic signed [P1_W-1:0] r_m1_p2;
    logic                   r_m2_v;
    t_ext                   r_m2;
    logic signed [Q1_W-1:0] r_m2_q1;
    logic signed [Q1_W-1:0] r_m2_q2;

    logic  r_e_v;
    t_seg  r_e;
    logic  r_c1_v;
    t_seg  r_c1;
    t_diff r_c1_du;
    t_diff r_c1_dv;
    logic  r_c1_gt;
    logic  r_c1_eq;

    logic  r_d2_v [0:DIV_LAT-1];
    t_clip r_d2   [0:DIV_LAT-1];
    t_quot div2_q;

    logic                   r_k1_v;
    t_clip                  r_k1;
    logic signed [PL_W-1:0] r_k1_lol;
    logic signed [PH_W-1:0] r_k1_loh;
    logic signed [PL_W-1:0] r_k1_hil;
    logic signed [PH_W-1:0] r_k1_hih;
    logic                   r_k2_v;
    t_clip                  r_k2;
    logic signed [P2_W-1:0] r_k2_plo;
    logic signed [P2_W-1:0] r_k2_phi;
    logic                   r_k3_v;
    t_clip                  r_k3;
    logic signed [Q2_W-1:0] r_k3_qlo;
    logic signed [Q2_W-1:0] r_k3_qhi;

    logic      r_o_v;
    t_line_out r_o;
    logic      r_sk_v;
    t_line_out r_sk;

    // next values
    t_diff                  n_s2_dx;
    t_diff                  n_s2_dy;
    t_diff                  div1_num;
    t_diff                  div1_den;
    t_ext                   n_ext;
    logic signed [P1_W-1:0] n_m1_p1;
    logic signed [P1_W-1:0] n_m1_p2;
    logic signed [Q1_W-1:0] n_m2_q1;
    logic signed [Q1_W-1:0] n_m2_q2;
    t_seg                   n_e;
    t_diff                  n_c1_du;
    t_diff                  n_c1_dv;
    logic                   n_c1_gt;
    logic                   n_c1_eq;
    t_clip                  n_clip;
    logic signed [PL_W-1:0] n_k1_lol;
    logic signed [PH_W-1:0] n_k1_loh;
    logic signed [PL_W-1:0] n_k1_hil;
    logic signed [PH_W-1:0] n_k1_hih;
    logic signed [P2_W-1:0] n_k2_plo;
    logic signed [P2_W-1:0] n_k2_phi;
    logic signed [Q2_W-1:0] n_k3_qlo;
    logic signed [Q2_W-1:0] n_k3_qhi;
    t_line_out              n_o;

    assign take = r_o_v & ~i_out_stall;
    assign en   = ~r_sk_v;
    assign inc  = en & r_k3_v;

    // S1 -> S2: differences
    always_comb begin
        n_s2_dx = t_diff'(r_s1.line_x2) - t_diff'(r_s1.line_x1);
        n_s2_dy = t_diff'(r_s1.line_y2) - t_diff'(r_s1.line_y1);
    end

    // S2: branch select, extend-step operands
    always_comb begin
        logic [DIFF_W-1:0] adx;
        logic [DIFF_W-1:0] ady;
        t_coord            b0;
        adx = r_s2_dx[DIFF_W-1] ? DIFF_W'(-r_s2_dx) : DIFF_W'(r_s2_dx);
        ady = r_s2_dy[DIFF_W-1] ? DIFF_W'(-r_s2_dy) : DIFF_W'(r_s2_dy);
        n_ext.steep = adx < ady;
        if (n_ext.steep) begin
            div1_num  = r_s2_dx;
            div1_den  = r_s2_dy;
            n_ext.a0  = r_s2.line_x1;
            b0        = r_s2.line_y1;
            n_ext.t1  = r_s2.rect_top;
            n_ext.t2  = r_s2.rect_bottom;
            n_ext.ou1 = r_s2.line_x1;
            n_ext.ov1 = r_s2.line_y1;
            n_ext.ou2 = r_s2.line_x2;
            n_ext.ov2 = r_s2.line_y2;
            n_ext.lo  = r_s2.rect_left;
            n_ext.hi  = r_s2.rect_right;
        end else begin
            div1_num  = r_s2_dy;
            div1_den  = r_s2_dx;
            n_ext.a0  = r_s2.line_y1;
            b0        = r_s2.line_x1;
            n_ext.t1  = r_s2.rect_left;
            n_ext.t2  = r_s2.rect_right;
            n_ext.ou1 = r_s2.line_y1;
            n_ext.ov1 = r_s2.line_x1;
            n_ext.ou2 = r_s2.line_y2;
            n_ext.ov2 = r_s2.line_x2;
            n_ext.lo  = r_s2.rect_top;
            n_ext.hi  = r_s2.rect_bottom;
        end
        n_ext.deg = (div1_den == '0);
        n_ext.d1  = t_diff'(n_ext.t1) - t_diff'(b0);
        n_ext.d2  = t_diff'(n_ext.t2) - t_diff'(b0);
    end

    slrc_div u_div_ext (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (div1_num),
        .i_den  (div1_den),
        .o_quot (div1_q)
    );

    // extend step: multiply, truncate toward zero, add and saturate
    always_comb begin
        logic signed [S1_W-1:0] s1;
        s1      = div1_q[S1_W-1:0];
        n_m1_p1 = r_d1[DIV_LAT-1].d1 * s1;
        n_m1_p2 = r_d1[DIV_LAT-1].d2 * s1;
    end

    always_comb begin
        logic signed [P1_W-1:0] t1;
        logic signed [P1_W-1:0] t2;
        t1      = r_m1_p1 + P1_W'({SLOPE_FRAC{r_m1_p1[P1_W-1]}});
        t2      = r_m1_p2 + P1_W'({SLOPE_FRAC{r_m1_p2[P1_W-1]}});
        n_m2_q1 = t1[P1_W-1:SLOPE_FRAC];
        n_m2_q2 = t2[P1_W-1:SLOPE_FRAC];
    end

    always_comb begin
        n_e.steep = r_m2.steep;
        n_e.lo    = r_m2.lo;
        n_e.hi    = r_m2.hi;
        if (r_m2.deg) begin
            n_e.u1 = r_m2.ou1;
            n_e.v1 = r_m2.ov1;
            n_e.u2 = r_m2.ou2;
            n_e.v2 = r_m2.ov2;
        end else begin
            n_e.u1 = sat_e(A1_W'(r_m2.a0) + A1_W'(r_m2_q1));
            n_e.v1 = r_m2.t1;
            n_e.u2 = sat_e(A1_W'(r_m2.a0) + A1_W'(r_m2_q2));
            n_e.v2 = r_m2.t2;
        end
    end

    // clip step operands
    always_comb begin
        n_c1_du = t_diff'(r_e.u2) - t_diff'(r_e.u1);
        n_c1_dv = t_diff'(r_e.v2) - t_diff'(r_e.v1);
        n_c1_gt = r_e.u1 > r_e.u2;
        n_c1_eq = r_e.u1 == r_e.u2;
    end

    always_comb begin
        n_clip.steep   = r_c1.steep;
        n_clip.eq      = r_c1_eq;
        n_clip.au      = r_c1_gt ? r_c1.u2 : r_c1.u1;
        n_clip.av      = r_c1_gt ? r_c1.v2 : r_c1.v1;
        n_clip.bu      = r_c1_gt ? r_c1.u1 : r_c1.u2;
        n_clip.bv      = r_c1_gt ? r_c1.v1 : r_c1.v2;
        n_clip.lo      = r_c1.lo;
        n_clip.hi      = r_c1.hi;
        n_clip.v1      = r_c1.v1;
        n_clip.outside = (n_clip.bu < r_c1.lo) || (n_clip.au > r_c1.hi);
        n_clip.nlo     = n_clip.au < r_c1.lo;
        n_clip.nhi     = n_clip.bu > r_c1.hi;
        n_clip.dlo     = t_diff'(r_c1.lo) - t_diff'(r_c1.u1);
        n_clip.dhi     = t_diff'(r_c1.hi) - t_diff'(r_c1.u1);
    end

    slrc_div u_div_clip (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_c1_dv),
        .i_den  (r_c1_du),
        .o_quot (div2_q)
    );

    // clip slope split into two partial products
    always_comb begin
        logic [SL_W-1:0]        sl;
        logic signed [SH_W-1:0] sh;
        sl       = div2_q[SL_W-1:0];
        sh       = div2_q[QS_W-1:SL_W];
        n_k1_lol = r_d2[DIV_LAT-1].dlo * $signed({1'b0, sl});
        n_k1_loh = r_d2[DIV_LAT-1].dlo * sh;
        n_k1_hil = r_d2[DIV_LAT-1].dhi * $signed({1'b0, sl});
        n_k1_hih = r_d2[DIV_LAT-1].dhi * sh;
    end

    always_comb begin
        n_k2_plo = (P2_W'(r_k1_loh) <<< SL_W) + P2_W'(r_k1_lol);
        n_k2_phi = (P2_W'(r_k1_hih) <<< SL_W) + P2_W'(r_k1_hil);
    end

    always_comb begin
        logic signed [P2_W-1:0] tl;
        logic signed [P2_W-1:0] th;
        tl       = r_k2_plo + P2_W'({SLOPE_FRAC{r_k2_plo[P2_W-1]}});
        th       = r_k2_phi + P2_W'({SLOPE_FRAC{r_k2_phi[P2_W-1]}});
        n_k3_qlo = tl[P2_W-1:SLOPE_FRAC];
        n_k3_qhi = th[P2_W-1:SLOPE_FRAC];
    end

    // final assembly back to x/y
    always_comb begin
        t_coord au;
        t_coord av;
        t_coord bu;
        t_coord bv;
        au = r_k3.au;
        av = r_k3.av;
        bu = r_k3.bu;
        bv = r_k3.bv;
        if (!r_k3.eq && r_k3.nlo) begin
            au = r_k3.lo;
            av = sat_k(A2_W'(r_k3.v1) + A2_W'(r_k3_qlo));
        end
        if (!r_k3.eq && r_k3.nhi) begin
            bu = r_k3.hi;
            bv = sat_k(A2_W'(r_k3.v1) + A2_W'(r_k3_qhi));
        end
        if (!r_k3.eq && r_k3.outside) begin
            n_o = '0;
            n_o.is_empty = 1'b1;
        end else begin
            n_o.is_empty = 1'b0;
            n_o.out_x1   = r_k3.steep ? au : av;
            n_o.out_y1   = r_k3.steep ? av : au;
            n_o.out_x2   = r_k3.steep ? bu : bv;
            n_o.out_y2   = r_k3.steep ? bv : bu;
        end
    end

    // valid bits and output skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_e_v  <= 1'b0;
            r_c1_v <= 1'b0;
            r_k1_v <= 1'b0;
            r_k2_v <= 1'b0;
            r_k3_v <= 1'b0;
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_d1_v[k] <= 1'b0;
                r_d2_v[k] <= 1'b0;
            end
        end else begin
            if (en) begin
                r_s1_v    <= i_in_valid;
                r_s2_v    <= r_s1_v;
                r_d1_v[0] <= r_s2_v;
                r_m1_v    <= r_d1_v[DIV_LAT-1];
                r_m2_v    <= r_m1_v;
                r_e_v     <= r_m2_v;
                r_c1_v    <= r_e_v;
                r_d2_v[0] <= r_c1_v;
                r_k1_v    <= r_d2_v[DIV_LAT-1];
                r_k2_v    <= r_k1_v;
                r_k3_v    <= r_k2_v;
                for (int k = 0; k < DIV_LAT - 1; k++) begin
                    r_d1_v[k+1] <= r_d1_v[k];
                    r_d2_v[k+1] <= r_d2_v[k];
                end
            end
            if (!r_o_v || take) begin
                if (r_sk_v) begin
                    r_o    <= r_sk;
                    r_o_v  <= 1'b1;
                    r_sk_v <= 1'b0;
                end else begin
                    r_o_v <= inc;
                    if (inc) begin
                        r_o <= n_o;
                    end
                end
            end else if (inc) begin
                r_sk_v <= 1'b1;
                r_sk   <= n_o;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1     <= i_in_data;
            r_s2     <= r_s1;
            r_s2_dx  <= n_s2_dx;
            r_s2_dy  <= n_s2_dy;
            r_d1[0]  <= n_ext;
            r_m1     <= r_d1[DIV_LAT-1];
            r_m1_p1  <= n_m1_p1;
            r_m1_p2  <= n_m1_p2;
            r_m2     <= r_m1;
            r_m2_q1  <= n_m2_q1;
            r_m2_q2  <= n_m2_q2;
            r_e      <= n_e;
            r_c1     <= r_e;
            r_c1_du  <= n_c1_du;
            r_c1_dv  <= n_c1_dv;
            r_c1_gt  <= n_c1_gt;
            r_c1_eq  <= n_c1_eq;
            r_d2[0]  <= n_clip;
            r_k1     <= r_d2[DIV_LAT-1];
            r_k1_lol <= n_k1_lol;
            r_k1_loh <= n_k1_loh;
            r_k1_hil <= n_k1_hil;
            r_k1_hih <= n_k1_hih;
            r_k2     <= r_k1;
            r_k2_plo <= n_k2_plo;
            r_k2_phi <= n_k2_phi;
            r_k3     <= r_k2;
            r_k3_qlo <= n_k3_qlo;
            r_k3_qhi <= n_k3_qhi;
            for (int k = 0; k < DIV_LAT - 1; k++) begin
                r_d1[k+1] <= r_d1[k];
                r_d2[k+1] <= r_d2[k];
            end
        end
    end

    assign o_in_stall  = r_sk_v;
    assign o_out_valid = r_o_v;
    assign o_out_data  = r_o;

`ifndef SYNTHESIS
    a_skid_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_o_v)
        else $error("skid holds a transaction while output register is empty");

    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && i_out_stall && !r_sk_v && r_k3_v) |=> r_sk_v)
        else $error("finished transaction not caught by skid");

    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |=> ($stable(r_k3_v) && $stable(r_s1_v)))
        else $error("pipeline moved while skid full");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_empty) |->
        (o_out_data.out_x1 == '0 && o_out_data.out_y1 == '0 &&
         o_out_data.out_x2 == '0 && o_out_data.out_y2 == '0))
        else $error("empty result with non-zero line");
`endif

endmodule

`default_nettype wire
